// ===== design/vtp_pkg.sv =====
// vtp_pkg: shared constants, register indexes and types for the vertex transform block.
// No dependencies.
`default_nettype none
package vtp_pkg;

   localparam int unsigned ENTRY_W  = 16;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned COL_W    = 48;
   localparam int unsigned COT_W    = 31;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned ADDR_W   = 6;
   localparam int unsigned DATA_W   = 64;

   localparam int unsigned MODE_VIEW_BIT = 0;
   localparam int unsigned MODE_PROJ_BIT = 1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT        = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DEPTH = 2'd2;

   localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REG_ROT_COL_X,
      REG_ROT_COL_Y,
      REG_ROT_COL_Z,
      REG_SHIFT_X,
      REG_SHIFT_Y,
      REG_SHIFT_Z,
      REG_COT_HALF_VIEW,
      REG_MODE
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [STATUS_W-1:0]       status;
   } result_type;

endpackage
`default_nettype wire

// ===== design/vertex_transform_project.sv =====
// vertex_transform_project: rotation, shift and perspective projection of one vertex.
// Depends on vtp_pkg.
//
// One vertex is accepted per clock while the output buffer is not full. The
// block is a pipeline: a difference stage, a product stage, a row-sum stage
// and a round/shift/saturate stage, then a restoring divider with one quotient
// bit per stage (31 + COORD_FRAC_BITS stages, 47 at the default), a stage that
// saturates w = cot/z, a stage for the w*x and w*y products, and a two-entry
// output buffer. The whole pipeline holds while the output buffer is full;
// with one result waiting, new vertices are still taken. Registers sit on an
// APB port at byte address 8*index, 64-bit data; write them only while the
// block is idle.
`default_nettype none
module vertex_transform_project #(
   parameter int unsigned COORD_FRAC_BITS  = 16,
   parameter int unsigned MATRIX_FRAC_BITS = 14
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [vtp_pkg::COORD_W-1:0]  req_in_x,
   input  wire logic signed [vtp_pkg::COORD_W-1:0]  req_in_y,
   input  wire logic signed [vtp_pkg::COORD_W-1:0]  req_in_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [vtp_pkg::COORD_W-1:0]       rsp_out_x,
   output logic signed [vtp_pkg::COORD_W-1:0]       rsp_out_y,
   output logic signed [vtp_pkg::COORD_W-1:0]       rsp_out_z,
   output logic [vtp_pkg::STATUS_W-1:0]             rsp_status,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [vtp_pkg::ADDR_W-1:0]          paddr,
   input  wire logic [vtp_pkg::DATA_W-1:0]          pwdata,
   output logic [vtp_pkg::DATA_W-1:0]               prdata,
   output logic                                     pready
);

   localparam int unsigned CW     = vtp_pkg::COORD_W;
   localparam int unsigned EW     = vtp_pkg::ENTRY_W;
   localparam int unsigned TW     = vtp_pkg::COT_W;
   localparam int unsigned DIFF_W = CW + 1;
   localparam int unsigned PROD_W = EW + DIFF_W;
   localparam int unsigned SUM_W  = PROD_W + 2;
   localparam int unsigned ACC_W  = SUM_W + 1;
   localparam int unsigned NUM_W  = vtp_pkg::COT_W + COORD_FRAC_BITS;
   localparam int unsigned MUL_W  = 2 * CW;

   localparam logic signed [SUM_W-1:0] MAT_HALF   = SUM_W'(1) << (MATRIX_FRAC_BITS - 1);
   localparam logic signed [MUL_W-1:0] COORD_HALF = MUL_W'(1) << (COORD_FRAC_BITS - 1);
   localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(32'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(32'h8000_0000);
   localparam logic [EW-1:0]    M_ONE     = EW'(1) << MATRIX_FRAC_BITS;
   localparam logic [TW-1:0]    COT_ONE   = TW'(1) << COORD_FRAC_BITS;

   typedef struct packed {
      logic signed [CW-1:0] r0;
      logic signed [CW-1:0] r1;
      logic signed [CW-1:0] r2;
      logic                 sat;
      logic                 zero;
      logic                 neg;
      logic [CW-1:0]        den;
      logic [CW-1:0]        rem;
      logic [NUM_W-1:0]     num_q;
   } div_type;

   function automatic div_type div_step(input div_type d);
      div_type    o;
      logic [CW:0] trial;
      o = d;
      trial = {d.rem, d.num_q[NUM_W-1]};
      if (trial >= {1'b0, d.den}) begin
         o.rem   = CW'(trial - {1'b0, d.den});
         o.num_q = {d.num_q[NUM_W-2:0], 1'b1};
      end else begin
         o.rem   = trial[CW-1:0];
         o.num_q = {d.num_q[NUM_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // ---------------- configuration ----------------
   logic [vtp_pkg::COL_W-1:0] col_ff [3];
   logic signed [CW-1:0]      shift_ff [3];
   logic [vtp_pkg::COT_W-1:0] cot_ff;
   logic [vtp_pkg::MODE_W-1:0] mode_ff;
   vtp_pkg::reg_index_type    reg_idx;
   logic                      csr_wr;

   assign pready  = 1'b1;
   assign reg_idx = vtp_pkg::reg_index_type'(paddr[vtp_pkg::ADDR_W-1:3]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff[0]   <= {32'd0, M_ONE};
         col_ff[1]   <= {16'd0, M_ONE, 16'd0};
         col_ff[2]   <= {M_ONE, 32'd0};
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
         cot_ff      <= COT_ONE;
         mode_ff     <= '0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            vtp_pkg::REG_ROT_COL_X:     col_ff[0]   <= pwdata[vtp_pkg::COL_W-1:0];
            vtp_pkg::REG_ROT_COL_Y:     col_ff[1]   <= pwdata[vtp_pkg::COL_W-1:0];
            vtp_pkg::REG_ROT_COL_Z:     col_ff[2]   <= pwdata[vtp_pkg::COL_W-1:0];
            vtp_pkg::REG_SHIFT_X:       shift_ff[0] <= pwdata[CW-1:0];
            vtp_pkg::REG_SHIFT_Y:       shift_ff[1] <= pwdata[CW-1:0];
            vtp_pkg::REG_SHIFT_Z:       shift_ff[2] <= pwdata[CW-1:0];
            vtp_pkg::REG_COT_HALF_VIEW: cot_ff      <= pwdata[vtp_pkg::COT_W-1:0];
            vtp_pkg::REG_MODE:          mode_ff     <= pwdata[vtp_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         vtp_pkg::REG_ROT_COL_X:     prdata = {16'd0, col_ff[0]};
         vtp_pkg::REG_ROT_COL_Y:     prdata = {16'd0, col_ff[1]};
         vtp_pkg::REG_ROT_COL_Z:     prdata = {16'd0, col_ff[2]};
         vtp_pkg::REG_SHIFT_X:       prdata = {32'd0, shift_ff[0]};
         vtp_pkg::REG_SHIFT_Y:       prdata = {32'd0, shift_ff[1]};
         vtp_pkg::REG_SHIFT_Z:       prdata = {32'd0, shift_ff[2]};
         vtp_pkg::REG_COT_HALF_VIEW: prdata = {33'd0, cot_ff};
         vtp_pkg::REG_MODE:          prdata = {62'd0, mode_ff};
         default:                    prdata = '0;
      endcase
   end

   logic view_mode, proj_mode;
   assign view_mode = mode_ff[vtp_pkg::MODE_VIEW_BIT];
   assign proj_mode = mode_ff[vtp_pkg::MODE_PROJ_BIT];

   // ---------------- pipeline control ----------------
   logic [1:0] cnt_ff, cnt_in;
   logic       adv;
   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;

   // ---------------- stage 0: view difference ----------------
   logic                     v0_ff;
   logic signed [DIFF_W-1:0] p_ff [3];
   logic signed [DIFF_W-1:0] p_in [3];
   logic signed [CW-1:0]     req_in [3];
   assign req_in[0] = req_in_x;
   assign req_in[1] = req_in_y;
   assign req_in[2] = req_in_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (view_mode) p_in[i] = {req_in[i][CW-1], req_in[i]} - {shift_ff[i][CW-1], shift_ff[i]};
         else           p_in[i] = {req_in[i][CW-1], req_in[i]};
      end
   end

   // ---------------- stage 1: products ----------------
   logic                     v1_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(col_ff[c][EW*r +: EW]) * p_ff[c];
         end
      end
   end

   // ---------------- stage 2: row sums ----------------
   logic                    v2_ff;
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = {{2{prod_ff[r][0][PROD_W-1]}}, prod_ff[r][0]}
                   + {{2{prod_ff[r][1][PROD_W-1]}}, prod_ff[r][1]}
                   + {{2{prod_ff[r][2][PROD_W-1]}}, prod_ff[r][2]} + MAT_HALF;
      end
   end

   // ---------------- stage 3: round, shift, saturate ----------------
   logic                 v3_ff;
   logic signed [CW-1:0] r_ff [3];
   logic signed [CW-1:0] r_in [3];
   logic                 sat3_ff, sat3_in;

   always_comb begin
      logic signed [SUM_W-1:0] shifted;
      logic signed [ACC_W-1:0] acc;
      sat3_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         shifted = sum_ff[r] >>> MATRIX_FRAC_BITS;
         acc = {shifted[SUM_W-1], shifted};
         if (!view_mode) acc = acc + {{(ACC_W-CW){shift_ff[r][CW-1]}}, shift_ff[r]};
         if (acc[ACC_W-1:CW-1] == {(ACC_W-CW+1){acc[CW-1]}}) begin
            r_in[r] = acc[CW-1:0];
         end else begin
            r_in[r] = acc[ACC_W-1] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX;
            sat3_in = 1'b1;
         end
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic    vd_ff [NUM_W];
   div_type div_ff [NUM_W];
   div_type div_in [NUM_W];
   div_type div_init;

   always_comb begin
      div_init.r0    = r_ff[0];
      div_init.r1    = r_ff[1];
      div_init.r2    = r_ff[2];
      div_init.sat   = sat3_ff;
      div_init.zero  = (r_ff[2] == '0);
      div_init.neg   = r_ff[2][CW-1];
      div_init.den   = r_ff[2][CW-1] ? CW'(-r_ff[2]) : r_ff[2];
      div_init.rem   = '0;
      div_init.num_q = {cot_ff, {COORD_FRAC_BITS{1'b0}}};
      div_in[0] = div_step(div_init);
      for (int j = 1; j < NUM_W; j++) div_in[j] = div_step(div_ff[j-1]);
   end

   // ---------------- w stage: sign and saturate the quotient ----------------
   logic                 vw_ff;
   logic signed [CW-1:0] w_ff, w_in;
   logic                 wsat_ff, wsat_in;
   div_type              dw_ff;

   always_comb begin
      logic [NUM_W-1:0] q;
      q = div_ff[NUM_W-1].num_q;
      wsat_in = 1'b0;
      if (div_ff[NUM_W-1].neg) begin
         if (q > Q_NEG_MAX) begin
            w_in    = vtp_pkg::SAT_MIN;
            wsat_in = 1'b1;
         end else begin
            w_in = CW'(-q);
         end
      end else if (q > Q_POS_MAX) begin
         w_in    = vtp_pkg::SAT_MAX;
         wsat_in = 1'b1;
      end else begin
         w_in = q[CW-1:0];
      end
   end

   // ---------------- multiply stage: w*x and w*y ----------------
   logic                    vm_ff;
   logic signed [MUL_W-1:0] px_ff, py_ff;
   logic signed [CW-1:0]    wm_ff;
   logic                    wsatm_ff;
   div_type                 dm_ff;

   // ---------------- result assembly ----------------
   vtp_pkg::result_type res_in;

   always_comb begin
      logic signed [MUL_W-1:0] rx, ry;
      logic                    xs, ys;
      logic signed [CW-1:0]    ox, oy;
      rx = (px_ff + COORD_HALF) >>> COORD_FRAC_BITS;
      ry = (py_ff + COORD_HALF) >>> COORD_FRAC_BITS;
      xs = (rx[MUL_W-1:CW-1] != {(MUL_W-CW+1){rx[CW-1]}});
      ys = (ry[MUL_W-1:CW-1] != {(MUL_W-CW+1){ry[CW-1]}});
      ox = xs ? (rx[MUL_W-1] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX) : rx[CW-1:0];
      oy = ys ? (ry[MUL_W-1] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX) : ry[CW-1:0];
      if (!proj_mode) begin
         res_in.x      = dm_ff.r0;
         res_in.y      = dm_ff.r1;
         res_in.z      = dm_ff.r2;
         res_in.status = dm_ff.sat ? vtp_pkg::STATUS_SAT : vtp_pkg::STATUS_OK;
      end else if (dm_ff.zero) begin
         // zero depth: push x, y to the rail of their sign
         res_in.x = (dm_ff.r0 == '0) ? '0 :
                    (dm_ff.r0[CW-1] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX);
         res_in.y = (dm_ff.r1 == '0) ? '0 :
                    (dm_ff.r1[CW-1] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX);
         res_in.z      = vtp_pkg::SAT_MAX;
         res_in.status = vtp_pkg::STATUS_ZERO_DEPTH;
      end else begin
         res_in.x      = ox;
         res_in.y      = oy;
         res_in.z      = wm_ff;
         res_in.status = (dm_ff.sat || wsatm_ff || xs || ys) ?
                         vtp_pkg::STATUS_SAT : vtp_pkg::STATUS_OK;
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int j = 0; j < NUM_W; j++) vd_ff[j] <= 1'b0;
         vw_ff <= 1'b0;
         vm_ff <= 1'b0;
      end else if (adv) begin
         v0_ff    <= req_valid;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vd_ff[0] <= v3_ff;
         for (int j = 1; j < NUM_W; j++) vd_ff[j] <= vd_ff[j-1];
         vw_ff <= vd_ff[NUM_W-1];
         vm_ff <= vw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         r_ff    <= r_in;
         sat3_ff <= sat3_in;
         for (int j = 0; j < NUM_W; j++) div_ff[j] <= div_in[j];
         w_ff     <= w_in;
         wsat_ff  <= wsat_in;
         dw_ff    <= div_ff[NUM_W-1];
         px_ff    <= w_ff * dw_ff.r0;
         py_ff    <= w_ff * dw_ff.r1;
         wm_ff    <= w_ff;
         wsatm_ff <= wsat_ff;
         dm_ff    <= dw_ff;
      end
   end

   // ---------------- two-entry output buffer ----------------
   vtp_pkg::result_type q0_ff, q1_ff;
   logic push, pop;
   assign push = adv && vm_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push)                q0_ff <= (cnt_ff == 2'd1) ? res_in : q1_ff;
         else if (cnt_ff == 2'd2) q0_ff <= q1_ff;
         if (push && cnt_ff == 2'd2) q1_ff <= res_in;
      end else if (push) begin
         if (cnt_ff == 2'd0) q0_ff <= res_in;
         else                q1_ff <= res_in;
      end
   end

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_out_x  = q0_ff.x;
   assign rsp_out_y  = q0_ff.y;
   assign rsp_out_z  = q0_ff.z;
   assign rsp_status = q0_ff.status;

endmodule
`default_nettype wire

// ===== design/vtp_checker.sv =====
// vtp_checker: port-level checks for vertex_transform_project, plus its bind.
// Depends on vtp_pkg.
`default_nettype none
module vtp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [vtp_pkg::COORD_W-1:0] rsp_out_x,
   input wire logic signed [vtp_pkg::COORD_W-1:0] rsp_out_y,
   input wire logic signed [vtp_pkg::COORD_W-1:0] rsp_out_z,
   input wire logic [vtp_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic                               pready
);

   // a held transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                 && $stable(rsp_out_z) && $stable(rsp_status))
      else $error("result changed while stalled");

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vtp_pkg::STATUS_ZERO_DEPTH |-> rsp_out_z == vtp_pkg::SAT_MAX)
      else $error("zero depth result without saturated w");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == vtp_pkg::STATUS_OK || rsp_status == vtp_pkg::STATUS_SAT
                    || rsp_status == vtp_pkg::STATUS_ZERO_DEPTH)
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_out_z  (rsp_out_z),
   .rsp_status (rsp_status),
   .pready     (pready)
);
`default_nettype wire
